### src/lst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

    localparam int CNT_W  = 16;
    localparam int LINE_W = 8;
    localparam int EL_W   = 12;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 8;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_LINE_COMPARE = 3'd0;
    localparam logic [IDX_W-1:0] REG_IRQ_EN_VBL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_IRQ_EN_HBL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_IRQ_EN_MATCH = 3'd3;
    localparam logic [IDX_W-1:0] REG_FORCED_BLANK = 3'd4;

    typedef enum logic [1:0] {
        PH_DRAW  = 2'd0,
        PH_HBL   = 2'd1,
        PH_VDRAW = 2'd2,
        PH_VHBL  = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase                    phase;
        logic signed [CNT_W-1:0]   counter;
        logic [LINE_W-1:0]         line;
        logic                      hbl_done;
        logic                      vbl;
        logic                      hbl;
        logic                      match;
    } t_state;

    typedef struct packed {
        logic [LINE_W-1:0] line_compare;
        logic              irq_en_vbl;
        logic              irq_en_hbl;
        logic              irq_en_match;
        logic              forced_blank;
    } t_cfg;

    typedef struct packed {
        logic [LINE_W-1:0]       current_line;
        logic                    vblank_flag;
        logic                    hblank_flag;
        logic                    match_flag;
        logic                    irq_vblank;
        logic                    irq_hblank;
        logic                    irq_match;
        logic                    phase_changed;
        logic                    draw_request;
        logic [LINE_W-1:0]       draw_line;
        logic                    draw_blank;
        logic signed [CNT_W-1:0] remaining_clocks;
    } t_result;

endpackage

`default_nettype wire

### src/lcd_scanline_timing.sv
`timescale 1ns / 1ps
`default_nettype none

// lcd scanline timing generator
// input channel (i_in_valid / o_in_ready) carries one item: the number of
// clocks elapsed since the previous item; the block takes it off the
// remaining-clock counter of the current phase and advances at most one phase
// output channel (o_out_valid / i_out_ready) returns exactly one result item
// per input item: line counter, status flags, interrupt pulses, draw request
// latency: the result is valid in the cycle after the input item is accepted
// throughput: one item per cycle; the step is one subtract, one compare and a
// small phase update between the state registers and the result register
// when the receiver stalls the result register holds its item and o_in_ready
// falls, so no item is lost; ready comes back as soon as the result is taken
// configuration: i_cfg_we with i_cfg_index / i_cfg_data, one register per
// cycle; the user must write only while no item is in flight (not enforced);
// unknown indexes are ignored; reset (sync, active low): line 0, draw phase,
// full draw period left, all flags and enables clear, no result pending
module lcd_scanline_timing #(
    parameter int DRAW_CLOCKS      = 960,
    parameter int HBLANK_CLOCKS    = 272,
    parameter int VISIBLE_LINES    = 160,
    parameter int TOTAL_LINES      = 228,
    parameter int HBLANK_FLAG_LATE = 1006
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [lst_pkg::IDX_W-1:0]         i_cfg_index,
    input  wire logic [lst_pkg::DATA_W-1:0]        i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [lst_pkg::EL_W-1:0]          i_elapsed_clocks,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [lst_pkg::LINE_W-1:0]             o_current_line,
    output logic                                   o_vblank_flag,
    output logic                                   o_hblank_flag,
    output logic                                   o_match_flag,
    output logic                                   o_irq_vblank,
    output logic                                   o_irq_hblank,
    output logic                                   o_irq_match,
    output logic                                   o_phase_changed,
    output logic                                   o_draw_request,
    output logic [lst_pkg::LINE_W-1:0]             o_draw_line,
    output logic                                   o_draw_blank,
    output logic signed [lst_pkg::CNT_W-1:0]       o_remaining_clocks
);

    lst_pkg::t_cfg    r_cfg;
    lst_pkg::t_state  r_state;
    lst_pkg::t_state  n_state;
    lst_pkg::t_result step_res;
    lst_pkg::t_result out_res;
    logic             accept;
    logic             space;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lst_pkg::REG_LINE_COMPARE: r_cfg.line_compare <= i_cfg_data;
                lst_pkg::REG_IRQ_EN_VBL:   r_cfg.irq_en_vbl   <= i_cfg_data[0];
                lst_pkg::REG_IRQ_EN_HBL:   r_cfg.irq_en_hbl   <= i_cfg_data[0];
                lst_pkg::REG_IRQ_EN_MATCH: r_cfg.irq_en_match <= i_cfg_data[0];
                lst_pkg::REG_FORCED_BLANK: r_cfg.forced_blank <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // combinational step from the current timing state
    lst_step #(
        .DRAW_CLOCKS      (DRAW_CLOCKS),
        .HBLANK_CLOCKS    (HBLANK_CLOCKS),
        .VISIBLE_LINES    (VISIBLE_LINES),
        .TOTAL_LINES      (TOTAL_LINES),
        .HBLANK_FLAG_LATE (HBLANK_FLAG_LATE)
    ) u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_elapsed (i_elapsed_clocks),
        .o_state   (n_state),
        .o_result  (step_res)
    );

    // timing state advances once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: lst_pkg::PH_DRAW, counter: lst_pkg::CNT_W'(DRAW_CLOCKS),
                         line: '0, hbl_done: 1'b0, vbl: 1'b0, hbl: 1'b0, match: 1'b0};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result register, parts the two channels
    lst_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (step_res),
        .i_out_ready (i_out_ready),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_result    (out_res)
    );

    assign o_current_line     = out_res.current_line;
    assign o_vblank_flag      = out_res.vblank_flag;
    assign o_hblank_flag      = out_res.hblank_flag;
    assign o_match_flag       = out_res.match_flag;
    assign o_irq_vblank       = out_res.irq_vblank;
    assign o_irq_hblank       = out_res.irq_hblank;
    assign o_irq_match        = out_res.irq_match;
    assign o_phase_changed    = out_res.phase_changed;
    assign o_draw_request     = out_res.draw_request;
    assign o_draw_line        = out_res.draw_line;
    assign o_draw_blank       = out_res.draw_blank;
    assign o_remaining_clocks = out_res.remaining_clocks;

`ifndef ASSERT_OFF
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("item accepted while result register full");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted item gave no result");

    a_draw_req_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_draw_request) |-> (o_phase_changed && !o_vblank_flag))
        else $error("draw request outside visible draw end");

    a_vbl_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state.phase == lst_pkg::PH_DRAW) || (r_state.phase == lst_pkg::PH_HBL))
        |-> !r_state.vbl)
        else $error("vblank flag set in visible phase");
`endif

endmodule

`default_nettype wire

### src/lst_step.sv
`timescale 1ns / 1ps
`default_nettype none

module lst_step #(
    parameter int DRAW_CLOCKS      = 960,
    parameter int HBLANK_CLOCKS    = 272,
    parameter int VISIBLE_LINES    = 160,
    parameter int TOTAL_LINES      = 228,
    parameter int HBLANK_FLAG_LATE = 1006
) (
    input  var lst_pkg::t_state             i_state,
    input  var lst_pkg::t_cfg               i_cfg,
    input  wire logic [lst_pkg::EL_W-1:0]   i_elapsed,
    output lst_pkg::t_state                 o_state,
    output lst_pkg::t_result                o_result
);

    localparam logic signed [lst_pkg::CNT_W-1:0] P_DRAW = lst_pkg::CNT_W'(DRAW_CLOCKS);
    localparam logic signed [lst_pkg::CNT_W-1:0] P_HBL  = lst_pkg::CNT_W'(HBLANK_CLOCKS);
    localparam int LATE_THR = HBLANK_CLOCKS - (HBLANK_FLAG_LATE - DRAW_CLOCKS);
    localparam logic [lst_pkg::LINE_W-1:0] L_VIS  = lst_pkg::LINE_W'(VISIBLE_LINES);
    localparam logic [lst_pkg::LINE_W-1:0] L_LAST = lst_pkg::LINE_W'(TOTAL_LINES - 1);
    localparam logic [lst_pkg::LINE_W-1:0] L_TOT  = lst_pkg::LINE_W'(TOTAL_LINES);

    logic signed [lst_pkg::CNT_W:0]   diff;
    logic signed [lst_pkg::CNT_W-1:0] sat;
    logic                             expired;
    logic                             late_hit;
    logic [lst_pkg::LINE_W-1:0]       nl;
    logic [lst_pkg::LINE_W-1:0]       start_line;
    logic                             line_start;
    logic                             hit;

    // subtract with saturation at the negative bound
    assign diff = {i_state.counter[lst_pkg::CNT_W-1], i_state.counter}
                - $signed({1'b0, {(lst_pkg::CNT_W - lst_pkg::EL_W){1'b0}}, i_elapsed});
    assign sat  = (diff[lst_pkg::CNT_W] != diff[lst_pkg::CNT_W-1])
                ? {1'b1, {(lst_pkg::CNT_W-1){1'b0}}} : diff[lst_pkg::CNT_W-1:0];
    assign expired  = (sat <= 0);
    assign late_hit = (int'(sat) <= LATE_THR) && !i_state.hbl_done;
    assign nl = i_state.line + 1'b1;

    // line number at a line start, back to zero at the end of the frame
    assign start_line = ((i_state.phase == lst_pkg::PH_VHBL) && (nl == L_TOT)) ? '0 : nl;

    // next state
    always_comb begin
        o_state = i_state;
        o_state.counter = sat;
        unique case (i_state.phase)
            lst_pkg::PH_DRAW: begin
                if (expired) begin
                    o_state.phase    = lst_pkg::PH_HBL;
                    o_state.counter  = sat + P_HBL;
                    o_state.hbl_done = 1'b0;
                end
            end
            lst_pkg::PH_HBL: begin
                if (expired) begin
                    o_state.line    = nl;
                    o_state.hbl     = 1'b0;
                    o_state.counter = sat + P_DRAW;
                    if (nl == L_VIS) begin
                        o_state.vbl   = 1'b1;
                        o_state.phase = lst_pkg::PH_VDRAW;
                    end else begin
                        o_state.phase = lst_pkg::PH_DRAW;
                    end
                end else if (late_hit) begin
                    o_state.hbl      = 1'b1;
                    o_state.hbl_done = 1'b1;
                end
            end
            lst_pkg::PH_VDRAW: begin
                if (expired) begin
                    o_state.phase    = lst_pkg::PH_VHBL;
                    o_state.counter  = sat + P_HBL;
                    o_state.hbl_done = 1'b0;
                end
            end
            lst_pkg::PH_VHBL: begin
                if (expired) begin
                    o_state.line    = nl;
                    o_state.hbl     = 1'b0;
                    o_state.counter = sat + P_DRAW;
                    o_state.phase   = lst_pkg::PH_VDRAW;
                    if (nl == L_LAST) begin
                        o_state.vbl = 1'b0;
                    end else if (nl == L_TOT) begin
                        // wrap to top of frame
                        o_state.line  = '0;
                        o_state.vbl   = 1'b0;
                        o_state.phase = lst_pkg::PH_DRAW;
                    end
                end else if (late_hit) begin
                    o_state.hbl      = 1'b1;
                    o_state.hbl_done = 1'b1;
                end
            end
        endcase
        // line compare is evaluated at every line start
        if (line_start) begin
            o_state.match = hit;
        end
    end

    assign line_start = expired && ((i_state.phase == lst_pkg::PH_HBL)
                                 || (i_state.phase == lst_pkg::PH_VHBL));
    assign hit = (start_line == i_cfg.line_compare);

    // result
    always_comb begin
        o_result = '0;
        o_result.current_line     = o_state.line;
        o_result.vblank_flag      = o_state.vbl;
        o_result.hblank_flag      = o_state.hbl;
        o_result.match_flag       = o_state.match;
        o_result.remaining_clocks = o_state.counter;
        o_result.irq_match        = line_start && hit && i_cfg.irq_en_match;
        unique case (i_state.phase)
            lst_pkg::PH_DRAW: begin
                if (expired) begin
                    o_result.draw_request  = 1'b1;
                    o_result.draw_line     = i_state.line;
                    o_result.draw_blank    = i_cfg.forced_blank;
                    o_result.irq_hblank    = i_cfg.irq_en_hbl;
                    o_result.phase_changed = 1'b1;
                end
            end
            lst_pkg::PH_HBL: begin
                if (expired) begin
                    o_result.phase_changed = 1'b1;
                    o_result.irq_vblank    = (nl == L_VIS) && i_cfg.irq_en_vbl;
                end
            end
            lst_pkg::PH_VDRAW: begin
                if (expired) begin
                    o_result.irq_hblank = i_cfg.irq_en_hbl;
                end
            end
            lst_pkg::PH_VHBL: begin
                o_result.phase_changed = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/lst_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lst_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  var lst_pkg::t_result     i_result,
    input  wire logic                i_out_ready,
    output logic                     o_space,
    output logic                     o_out_valid,
    output lst_pkg::t_result         o_result
);

    logic             r_valid;
    logic             n_valid;
    lst_pkg::t_result r_result;

    // free when empty or when the held item leaves this cycle
    assign o_space = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

### tb/sv/tb_lcd_scanline_timing.sv
`timescale 1ns / 1ps

module tb_lcd_scanline_timing;

    // timing of the block under test, passed down so both sides agree
    localparam int DRAW_CLOCKS      = 960;
    localparam int HBLANK_CLOCKS    = 272;
    localparam int VISIBLE_LINES    = 160;
    localparam int TOTAL_LINES      = 228;
    localparam int HBLANK_FLAG_LATE = 1006;

    // hblank flag rises once this few clocks are left in the hblank period
    localparam int HBL_FLAG_AT = HBLANK_CLOCKS - (HBLANK_FLAG_LATE - DRAW_CLOCKS);
    localparam int CNT_FLOOR   = -32768;

    // first index past the register file, used for the ignored write
    localparam int REG_COUNT = 5;

    localparam int IDLE_PCT     = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 600;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 240;

    typedef enum int {
        MODE_BALANCED,
        MODE_FAST
    } t_mode;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         cfg_we = 1'b0;
    logic [lst_pkg::IDX_W-1:0]    cfg_index = '0;
    logic [lst_pkg::DATA_W-1:0]   cfg_data = '0;

    logic                         in_valid = 1'b0;
    logic [lst_pkg::EL_W-1:0]     in_elapsed = '0;
    logic                         out_ready = 1'b0;

    wire logic                             in_ready;
    wire logic                             out_valid;
    wire logic [lst_pkg::LINE_W-1:0]       current_line;
    wire logic                             vblank_flag;
    wire logic                             hblank_flag;
    wire logic                             match_flag;
    wire logic                             irq_vblank;
    wire logic                             irq_hblank;
    wire logic                             irq_match;
    wire logic                             phase_changed;
    wire logic                             draw_request;
    wire logic [lst_pkg::LINE_W-1:0]       draw_line;
    wire logic                             draw_blank;
    wire logic signed [lst_pkg::CNT_W-1:0] remaining_clocks;

    lcd_scanline_timing #(
        .DRAW_CLOCKS      (DRAW_CLOCKS),
        .HBLANK_CLOCKS    (HBLANK_CLOCKS),
        .VISIBLE_LINES    (VISIBLE_LINES),
        .TOTAL_LINES      (TOTAL_LINES),
        .HBLANK_FLAG_LATE (HBLANK_FLAG_LATE)
    ) i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_elapsed_clocks   (in_elapsed),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_current_line     (current_line),
        .o_vblank_flag      (vblank_flag),
        .o_hblank_flag      (hblank_flag),
        .o_match_flag       (match_flag),
        .o_irq_vblank       (irq_vblank),
        .o_irq_hblank       (irq_hblank),
        .o_irq_match        (irq_match),
        .o_phase_changed    (phase_changed),
        .o_draw_request     (draw_request),
        .o_draw_line        (draw_line),
        .o_draw_blank       (draw_blank),
        .o_remaining_clocks (remaining_clocks)
    );

    // 4 ns clock
    initial begin
        forever #2 clk = ~clk;
    end

    // own copy of the timing state and of the register file
    lst_pkg::t_phase            tm_phase = lst_pkg::PH_DRAW;
    int                         tm_count = DRAW_CLOCKS;
    logic [lst_pkg::LINE_W-1:0] tm_line = '0;
    logic                       tm_hbl_done = 1'b0;
    logic                       tm_vbl = 1'b0;
    logic                       tm_hbl = 1'b0;
    logic                       tm_match = 1'b0;
    lst_pkg::t_cfg              regs = '0;

    logic [lst_pkg::EL_W-1:0] pending_elapsed[$];   // items waiting for the driver
    lst_pkg::t_result         line_status_due[$];   // predicted results, oldest first

    logic in_taken = 1'b0;
    logic calm = 1'b0;                      // no idling on either side
    int   n_items = 0;
    int   n_results = 0;
    int   n_err = 0;
    int   n_req = 0;
    int   n_sat = 0;
    int   n_vbl_start = 0;
    int   n_match_irq = 0;
    int   cycles = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    // line start: compare line with line_compare, returns the interrupt pulse
    function automatic logic line_match();
        if (tm_line == regs.line_compare) begin
            tm_match = 1'b1;
            return regs.irq_en_match;
        end
        tm_match = 1'b0;
        return 1'b0;
    endfunction

    // hblank flag set late in the hblank period, once per period
    function automatic void late_hblank();
        if (tm_count <= HBL_FLAG_AT && !tm_hbl_done) begin
            tm_hbl = 1'b1;
            tm_hbl_done = 1'b1;
        end
    endfunction

    // one step of the timing generator for one accepted item
    function automatic lst_pkg::t_result advance_scanline(input logic [lst_pkg::EL_W-1:0] el);
        lst_pkg::t_result r;
        r = '0;
        tm_count = tm_count - int'(el);
        if (tm_count < CNT_FLOOR) tm_count = CNT_FLOOR;

        case (tm_phase)
            lst_pkg::PH_DRAW: begin
                if (tm_count <= 0) begin
                    r.draw_request = 1'b1;
                    r.draw_line = tm_line;
                    r.draw_blank = regs.forced_blank;
                    r.irq_hblank = regs.irq_en_hbl;
                    r.phase_changed = 1'b1;
                    tm_phase = lst_pkg::PH_HBL;
                    tm_count = tm_count + HBLANK_CLOCKS;
                    tm_hbl_done = 1'b0;
                end
            end
            lst_pkg::PH_HBL: begin
                if (tm_count <= 0) begin
                    tm_line = tm_line + 1'b1;
                    tm_hbl = 1'b0;
                    if (tm_line == VISIBLE_LINES) begin
                        tm_vbl = 1'b1;
                        r.irq_vblank = regs.irq_en_vbl;
                        tm_phase = lst_pkg::PH_VDRAW;
                    end else begin
                        tm_phase = lst_pkg::PH_DRAW;
                    end
                    tm_count = tm_count + DRAW_CLOCKS;
                    r.irq_match = line_match();
                    r.phase_changed = 1'b1;
                end else begin
                    late_hblank();
                end
            end
            lst_pkg::PH_VDRAW: begin
                if (tm_count <= 0) begin
                    r.irq_hblank = regs.irq_en_hbl;
                    tm_phase = lst_pkg::PH_VHBL;
                    tm_count = tm_count + HBLANK_CLOCKS;
                    tm_hbl_done = 1'b0;
                end
            end
            default: begin
                if (tm_count <= 0) begin
                    tm_line = tm_line + 1'b1;
                    tm_hbl = 1'b0;
                    if (tm_line == TOTAL_LINES - 1) begin
                        tm_vbl = 1'b0;
                        tm_phase = lst_pkg::PH_VDRAW;
                    end else if (tm_line == TOTAL_LINES) begin
                        // wrap to line zero also clears vblank
                        tm_line = '0;
                        tm_vbl = 1'b0;
                        tm_phase = lst_pkg::PH_DRAW;
                    end else begin
                        tm_phase = lst_pkg::PH_VDRAW;
                    end
                    tm_count = tm_count + DRAW_CLOCKS;
                    r.irq_match = line_match();
                end else begin
                    late_hblank();
                end
            end
        endcase

        r.current_line = tm_line;
        r.vblank_flag = tm_vbl;
        r.hblank_flag = tm_hbl;
        r.match_flag = tm_match;
        r.remaining_clocks = tm_count[lst_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_err++;
        end
    endtask

    // monitor: results are compared before the newly accepted item is predicted
    always @(posedge clk) begin
        lst_pkg::t_result want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                n_results++;
                if (line_status_due.size() == 0) begin
                    $display("%0t: result with nothing expected, line %0d", $time, current_line);
                    n_err++;
                end else begin
                    want = line_status_due.pop_front();
                    check_field("current_line", want.current_line, current_line);
                    check_field("vblank_flag", want.vblank_flag, vblank_flag);
                    check_field("hblank_flag", want.hblank_flag, hblank_flag);
                    check_field("match_flag", want.match_flag, match_flag);
                    check_field("irq_vblank", want.irq_vblank, irq_vblank);
                    check_field("irq_hblank", want.irq_hblank, irq_hblank);
                    check_field("irq_match", want.irq_match, irq_match);
                    check_field("phase_changed", want.phase_changed, phase_changed);
                    check_field("draw_request", want.draw_request, draw_request);
                    check_field("draw_line", want.draw_line, draw_line);
                    check_field("draw_blank", want.draw_blank, draw_blank);
                    check_field("remaining_clocks", int'(want.remaining_clocks),
                                int'(remaining_clocks));
                end
            end
            if (in_valid && in_ready) begin
                n_items++;
                want = advance_scanline(in_elapsed);
                n_req += want.draw_request;
                n_vbl_start += (want.vblank_flag && want.phase_changed
                                && want.current_line == VISIBLE_LINES);
                n_match_irq += want.irq_match;
                n_sat += (int'(want.remaining_clocks) <= CNT_FLOOR + HBLANK_CLOCKS);
                line_status_due.push_back(want);
            end
        end
    end

    // driver: a new item only once the previous one has been taken
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_elapsed.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                in_elapsed <= pending_elapsed.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL lcd_scanline_timing");
            $finish;
        end
    end

    // all registers in consecutive cycles, then one write to an unused index
    task automatic load_regs(input lst_pkg::t_cfg c);
        logic [lst_pkg::DATA_W-1:0] junk;
        logic [lst_pkg::IDX_W-1:0]  spare;
        junk = lst_pkg::DATA_W'($urandom);
        spare = lst_pkg::IDX_W'(REG_COUNT + $urandom_range(2));
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= lst_pkg::REG_LINE_COMPARE;
        cfg_data <= c.line_compare;
        @(negedge clk);
        cfg_index <= lst_pkg::REG_IRQ_EN_VBL;
        cfg_data <= {junk[lst_pkg::DATA_W-1:1], c.irq_en_vbl};
        @(negedge clk);
        cfg_index <= lst_pkg::REG_IRQ_EN_HBL;
        cfg_data <= {junk[lst_pkg::DATA_W-2:0], c.irq_en_hbl};
        @(negedge clk);
        cfg_index <= lst_pkg::REG_IRQ_EN_MATCH;
        cfg_data <= {~junk[lst_pkg::DATA_W-1:1], c.irq_en_match};
        @(negedge clk);
        cfg_index <= lst_pkg::REG_FORCED_BLANK;
        cfg_data <= {~junk[lst_pkg::DATA_W-2:0], c.forced_blank};
        @(negedge clk);
        cfg_index <= spare;
        cfg_data <= junk;
        @(negedge clk);
        cfg_we <= 1'b0;
        regs = c;
        @(posedge clk);
    endtask

    // balanced mode roughly keeps pace with the line, fast mode runs a deficit
    function automatic logic [lst_pkg::EL_W-1:0] pick_elapsed(input t_mode mode);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) return '0;
        if (roll < 10) return '1;
        if (mode == MODE_BALANCED) begin
            if (roll < 50) return lst_pkg::EL_W'($urandom_range(255));
            return lst_pkg::EL_W'($urandom_range(1300, 100));
        end
        if (roll < 40) return lst_pkg::EL_W'($urandom_range(255));
        if (roll < 70) return lst_pkg::EL_W'($urandom_range(1300, 256));
        return lst_pkg::EL_W'($urandom_range(4095, 1300));
    endfunction

    task automatic wait_idle();
        while (pending_elapsed.size() != 0 || in_valid || line_status_due.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        lst_pkg::t_cfg c;
        t_mode         mode;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: compare on line 1, every interrupt and forced blank on
        c = '{line_compare: 8'd1, irq_en_vbl: 1'b1, irq_en_hbl: 1'b1,
              irq_en_match: 1'b1, forced_blank: 1'b1};
        load_regs(c);
        pending_elapsed.push_back('0);              // zero clocks, nothing moves
        pending_elapsed.push_back(lst_pkg::EL_W'(DRAW_CLOCKS - 1)); // one clock left in draw
        pending_elapsed.push_back(lst_pkg::EL_W'(1)); // draw ends on exactly zero
        // one clock above the hblank flag threshold
        pending_elapsed.push_back(lst_pkg::EL_W'(HBLANK_CLOCKS - HBL_FLAG_AT - 1));
        pending_elapsed.push_back(lst_pkg::EL_W'(1)); // hblank flag rises here
        pending_elapsed.push_back(lst_pkg::EL_W'(1)); // and is not set a second time
        pending_elapsed.push_back(lst_pkg::EL_W'(HBL_FLAG_AT - 1)); // line 1 starts, match
        pending_elapsed.push_back('1);
        pending_elapsed.push_back('1);
        pending_elapsed.push_back(12'hAAA);
        pending_elapsed.push_back(12'h555);
        // deep deficit, counter pinned at its negative bound
        repeat (8) pending_elapsed.push_back('1);
        // recovery with no clocks passing, one phase change per item
        repeat (4) pending_elapsed.push_back('0);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            c.line_compare = lst_pkg::LINE_W'($urandom_range(TOTAL_LINES - 1));
            c.irq_en_vbl = 1'($urandom);
            c.irq_en_hbl = 1'($urandom);
            c.irq_en_match = 1'($urandom);
            c.forced_blank = 1'($urandom);
            mode = MODE_FAST;
            case (p)
                0: c = '0;
                1: begin
                    c = '{line_compare: lst_pkg::LINE_W'(VISIBLE_LINES), irq_en_vbl: 1'b1,
                          irq_en_hbl: 1'b1, irq_en_match: 1'b1, forced_blank: 1'b1};
                    mode = MODE_BALANCED;
                end
                2: c.line_compare = '1;
                3: c = '{line_compare: lst_pkg::LINE_W'(TOTAL_LINES - 1), irq_en_vbl: 1'b1,
                         irq_en_hbl: 1'b1, irq_en_match: 1'b1, forced_blank: 1'b0};
                4: mode = MODE_BALANCED;
                default: c.line_compare = lst_pkg::LINE_W'(VISIBLE_LINES - 1);
            endcase
            load_regs(c);
            // one phase runs with no idling at all
            calm = (p == 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
                pending_elapsed.push_back(pick_elapsed(mode));
            wait_idle();
            calm = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d items and %0d results over several register settings",
                 n_items, n_results);
        $display("draw requests %0d, vblank starts %0d, match interrupts %0d, deep deficit %0d",
                 n_req, n_vbl_start, n_match_irq, n_sat);
        if (n_err == 0 && line_status_due.size() == 0) begin
            $display("PASS lcd_scanline_timing");
        end else begin
            $display("FAIL lcd_scanline_timing");
        end
        $finish;
    end

endmodule

### files.f
src/lst_pkg.sv
src/lst_step.sv
src/lst_out_stage.sv
src/lcd_scanline_timing.sv
tb/sv/tb_lcd_scanline_timing.sv
